>>> hdl/fcbp_pkg.sv
// fcbp_pkg: shared constants, command type and helpers for the fcb parser
// no dependencies; used by every module of the block

package fcbp_pkg;

  localparam int MAX_NAME_CHARS_DEF = 15;
  localparam int QUEUE_DEPTH_DEF    = 4;

  localparam int BLOCK_BYTES = 12;
  localparam logic [3:0] EXT_START = 4'd9;
  localparam logic [3:0] BLOCK_END = 4'd12;
  localparam logic [3:0] LAST_IDX  = 4'd11;
  localparam logic [3:0] NAME_START = 4'd1;

  localparam logic [7:0] CHAR_NUL   = 8'h00;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_P     = 8'h50;
  localparam logic [7:0] CHAR_LA    = 8'h61;
  localparam logic [7:0] CHAR_LZ    = 8'h7a;
  localparam logic [7:0] CHAR_QMARK = 8'h3f;
  localparam logic [7:0] CHAR_STAR  = 8'h2a;
  localparam logic [7:0] CHAR_DOT   = 8'h2e;
  localparam logic [7:0] CHAR_COLON = 8'h3a;
  localparam logic [7:0] CHAR_SPACE = 8'h20;
  localparam logic [7:0] CASE_DIFF  = 8'd32;

  typedef enum logic [2:0] {
    CMD_DRIVE     = 3'd0,
    CMD_TAKE      = 3'd1,
    CMD_TAKE2     = 3'd2,
    CMD_EMIT      = 3'd3,
    CMD_TAKE_EMIT = 3'd4
  } cmd_op_t;

  typedef struct packed {
    cmd_op_t    op;
    logic [7:0] a;
    logic [7:0] b;
  } cmd_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c inside {[CHAR_LA:CHAR_LZ]}) r = c - CASE_DIFF;
    return r;
  endfunction

endpackage

>>> hdl/fcbp_front.sv
// fcbp_front: accepts name characters, tracks drive prefix and char count
// depends on fcbp_pkg; pushes one command per classified item

module fcbp_front #(
  parameter int MAX_NAME_CHARS = fcbp_pkg::MAX_NAME_CHARS_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic [7:0]         name_char,
  output logic               push,
  output fcbp_pkg::cmd_t     cmd
);

  localparam int CW = $clog2(MAX_NAME_CHARS + 1);
  localparam logic [CW-1:0] MAX_C = CW'(MAX_NAME_CHARS);

  logic [CW-1:0] count, count_next;
  logic [7:0]    held;
  logic [7:0]    drv_char;
  logic          has_cmd;

  always_comb begin
    drv_char = fcbp_pkg::fold_case(held);
    has_cmd = 1'b0;
    count_next = count;
    cmd.op = fcbp_pkg::CMD_TAKE;
    cmd.a = name_char;
    cmd.b = name_char;
    if (name_char != fcbp_pkg::CHAR_NUL) begin
      if (count < MAX_C) begin
        count_next = count + CW'(1);
        if (count == CW'(1)) begin
          has_cmd = 1'b1;
          if (name_char == fcbp_pkg::CHAR_COLON) begin
            cmd.op = fcbp_pkg::CMD_DRIVE;
            if (drv_char inside {[fcbp_pkg::CHAR_A:fcbp_pkg::CHAR_P]}) begin
              cmd.a = drv_char - fcbp_pkg::CHAR_A + 8'd1;
            end else begin
              cmd.a = 8'd0;
            end
          end else begin
            cmd.op = fcbp_pkg::CMD_TAKE2;
            cmd.a = held;
          end
        end else if (count != CW'(0)) begin
          has_cmd = 1'b1;
        end
      end
    end else begin
      count_next = '0;
      has_cmd = 1'b1;
      cmd.a = held;
      cmd.op = (count == CW'(1)) ? fcbp_pkg::CMD_TAKE_EMIT : fcbp_pkg::CMD_EMIT;
    end
  end

  assign push = accept && has_cmd;

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      held <= '0;
    end else if (accept) begin
      count <= count_next;
      if (name_char != fcbp_pkg::CHAR_NUL && count == CW'(0)) held <= name_char;
    end
  end

endmodule

>>> hdl/fcbp_queue.sv
// fcbp_queue: small register fifo of commands between front and back
// depends on fcbp_pkg for the command type

module fcbp_queue #(
  parameter int DEPTH = fcbp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  fcbp_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           nonempty,
  output fcbp_pkg::cmd_t head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int NW = $clog2(DEPTH + 1);
  localparam logic [PW-1:0] LAST_P = PW'(DEPTH - 1);

  fcbp_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0] wr_ptr, rd_ptr;
  logic [NW-1:0] fill;

  assign full = (fill == NW'(DEPTH));
  assign nonempty = (fill != '0);
  assign head = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_cmd;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill <= '0;
    end else begin
      if (push) wr_ptr <= (wr_ptr == LAST_P) ? '0 : wr_ptr + PW'(1);
      if (pop) rd_ptr <= (rd_ptr == LAST_P) ? '0 : rd_ptr + PW'(1);
      if (push && !pop) fill <= fill + NW'(1);
      else if (pop && !push) fill <= fill - NW'(1);
    end
  end

endmodule

>>> hdl/fcbp_back.sv
// fcbp_back: executes commands on the 12-byte block and streams it out
// depends on fcbp_pkg; fed by fcbp_queue

module fcbp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_nonempty,
  input  fcbp_pkg::cmd_t q_head,
  output logic           pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [3:0]     byte_index,
  output logic [7:0]     byte_value,
  output logic           last_byte
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_CHAR = 4'b0010,
    ST_FILL = 4'b0100,
    ST_EMIT = 4'b1000
  } state_t;

  state_t     state;
  logic [7:0] block [fcbp_pkg::BLOCK_BYTES];
  logic [7:0] cur, nb;
  logic       pend_b, pend_emit;
  logic [3:0] wp, idx, limit;
  logic       in_ext;
  logic [7:0] fc;
  logic       load;

  assign limit = in_ext ? fcbp_pkg::BLOCK_END : fcbp_pkg::EXT_START;
  assign fc = fcbp_pkg::fold_case(cur);
  assign pop = (state == ST_IDLE) && q_nonempty;
  assign load = (state == ST_EMIT) && (!out_valid || out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      wp <= fcbp_pkg::NAME_START;
      in_ext <= 1'b0;
      pend_b <= 1'b0;
      pend_emit <= 1'b0;
      idx <= '0;
      out_valid <= 1'b0;
      block[0] <= 8'd0;
      for (int k = 1; k < fcbp_pkg::BLOCK_BYTES; k++) block[k] <= fcbp_pkg::CHAR_SPACE;
    end else begin
      if (load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;

      case (state)
        ST_IDLE: begin
          if (q_nonempty) begin
            cur <= q_head.a;
            nb <= q_head.b;
            pend_b <= (q_head.op == fcbp_pkg::CMD_TAKE2);
            pend_emit <= (q_head.op == fcbp_pkg::CMD_TAKE_EMIT);
            idx <= '0;
            case (q_head.op)
              fcbp_pkg::CMD_DRIVE: block[0] <= q_head.a;
              fcbp_pkg::CMD_EMIT:  state <= ST_EMIT;
              default:             state <= ST_CHAR;
            endcase
          end
        end
        ST_CHAR: begin
          if (fc == fcbp_pkg::CHAR_STAR) begin
            state <= ST_FILL;
          end else begin
            if (fc == fcbp_pkg::CHAR_DOT) begin
              in_ext <= 1'b1;
              wp <= fcbp_pkg::EXT_START;
            end else if (wp < limit) begin
              block[wp] <= fc;
              wp <= wp + 4'd1;
            end
            // second char of a pair, then the block, then back to idle
            if (pend_b) begin
              cur <= nb;
              pend_b <= 1'b0;
            end else if (pend_emit) begin
              state <= ST_EMIT;
            end else begin
              state <= ST_IDLE;
            end
          end
        end
        ST_FILL: begin
          if (wp < limit) begin
            block[wp] <= fcbp_pkg::CHAR_QMARK;
            wp <= wp + 4'd1;
          end else if (pend_b) begin
            cur <= nb;
            pend_b <= 1'b0;
            state <= ST_CHAR;
          end else if (pend_emit) begin
            state <= ST_EMIT;
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_EMIT: begin
          if (load) begin
            byte_index <= idx;
            byte_value <= block[idx];
            last_byte <= (idx == fcbp_pkg::LAST_IDX);
            block[idx] <= (idx == 4'd0) ? 8'd0 : fcbp_pkg::CHAR_SPACE;
            if (idx == fcbp_pkg::LAST_IDX) begin
              wp <= fcbp_pkg::NAME_START;
              in_ext <= 1'b0;
              state <= ST_IDLE;
            end else begin
              idx <= idx + 4'd1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

>>> hdl/filename_to_fcb_parser_unit.sv
// filename_to_fcb_parser_unit: top level of the file name to fcb parser
// depends on fcbp_pkg, fcbp_front, fcbp_queue, fcbp_back

// channel   direction  handshake              payload
// input     in         in_valid / in_ready    name_char[7:0]
// output    out        out_valid / out_ready  byte_index[3:0] byte_value[7:0] last_byte
//
// the front takes one item per cycle while the queue has room; the back pops a plain
// character and then stores it, stores both characters of a pair, takes a drive prefix
// with the pop alone, and on a star writes up to eight '?' and then leaves the fill
// a terminator sends twelve output beats, one per cycle while out_ready is high
// reset is synchronous and restores the block directly: no clearing pass
// in_ready drops only while the command queue is full; output stalls hold the back

module filename_to_fcb_parser_unit #(
  parameter int MAX_NAME_CHARS = fcbp_pkg::MAX_NAME_CHARS_DEF,
  parameter int QUEUE_DEPTH    = fcbp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] name_char,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [3:0] byte_index,
  output logic [7:0] byte_value,
  output logic       last_byte
);

  logic           q_full, q_nonempty, q_push, q_pop;
  fcbp_pkg::cmd_t push_cmd, head_cmd;

  // front side is free whenever the queue has room
  assign in_ready = !q_full;

  fcbp_front #(.MAX_NAME_CHARS(MAX_NAME_CHARS)) u_front (
    .clk       (clk),
    .rst       (rst),
    .accept    (in_valid && in_ready),
    .name_char (name_char),
    .push      (q_push),
    .cmd       (push_cmd)
  );

  fcbp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (push_cmd),
    .pop      (q_pop),
    .full     (q_full),
    .nonempty (q_nonempty),
    .head     (head_cmd)
  );

  fcbp_back u_back (
    .clk        (clk),
    .rst        (rst),
    .q_nonempty (q_nonempty),
    .q_head     (head_cmd),
    .pop        (q_pop),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .byte_index (byte_index),
    .byte_value (byte_value),
    .last_byte  (last_byte)
  );

  // the last byte of a block is always position eleven
  a_last_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && last_byte |-> byte_index == fcbp_pkg::LAST_IDX)
    else $error("last_byte on wrong position");

  // block bytes leave in order without gaps
  a_in_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !last_byte |=>
      out_valid && byte_index == $past(byte_index) + 4'd1)
    else $error("block byte order broken");

  // nothing is pushed into a full queue
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full)
    else $error("command queue overflow");

  // a valid output never shows a position beyond the block
  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> byte_index <= fcbp_pkg::LAST_IDX)
    else $error("byte_index out of range");

endmodule
